@@ src/tlpt_pkg.sv @@
package tlpt_pkg;

  localparam int DIR_ENTRIES = 1024;
  localparam int MAX_TABLES  = 64;

  localparam int DIR_IDX_W = $clog2(DIR_ENTRIES);
  localparam int SLOT_W    = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int DIR_ENT_W = SLOT_W + 1;
  localparam int NFT_W     = $clog2(MAX_TABLES + 1);

  localparam int PAGE_W     = 20;
  localparam int WORD_W     = 32;
  localparam int OFFS_W     = 12;
  localparam int POOL_CNT_W = 7;
  localparam int CMP_W      = (NFT_W > POOL_CNT_W) ? NFT_W : POOL_CNT_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 20;

  localparam logic [POOL_CNT_W-1:0] POOL_CNT_RESET = POOL_CNT_W'(8);
  localparam logic [OFFS_W-1:0]     ENTRY_FLAGS    = OFFS_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIR_BASE   = 8'd0,
    REG_POOL_COUNT = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

@@ src/tlpt_in_if.sv @@
interface tlpt_in_if;
  import tlpt_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] virt_page;
  logic [PAGE_W-1:0] phys_page;
  logic              run_end;

  modport source (output valid, output virt_page, output phys_page, output run_end,
                  input ready);
  modport sink (input valid, input virt_page, input phys_page, input run_end,
                output ready);
endinterface

@@ src/tlpt_out_if.sv @@
interface tlpt_out_if;
  import tlpt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 status;
  logic                 table_allocated;
  logic [DIR_IDX_W-1:0] dir_index;
  logic [WORD_W-1:0]    dir_word;
  logic [WORD_W-1:0]    pte_address;
  logic [WORD_W-1:0]    pte_word;
  logic                 run_end_echo;

  modport source (output valid, output status, output table_allocated, output dir_index,
                  output dir_word, output pte_address, output pte_word,
                  output run_end_echo, input ready);
  modport sink (input valid, input status, input table_allocated, input dir_index,
                input dir_word, input pte_address, input pte_word,
                input run_end_echo, output ready);
endinterface

@@ src/tlpt_cfg_if.sv @@
interface tlpt_cfg_if;
  import tlpt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/tlpt_ram.sv @@
module tlpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ src/tlpt_ctrl.sv @@
module tlpt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlpt_pkg::ctrl_sts_t sts,
  output tlpt_pkg::ctrl_cmd_t cmd
);
  import tlpt_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    cmd.clear_wr = (state_r == ST_CLEAR);
    cmd.capture  = (state_r == ST_IDLE) && in_valid && in_ready_r;
    cmd.commit   = (state_r == ST_LOOKUP) && !sts.out_busy;
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) begin
          state_nxt    = ST_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd.capture) begin
          state_nxt    = ST_LOOKUP;
          in_ready_nxt = 1'b0;
        end
      end
      ST_LOOKUP: begin
        if (cmd.commit) begin
          state_nxt    = ST_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt    = ST_CLEAR;
        in_ready_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;
endmodule

@@ src/tlpt_dp.sv @@
module tlpt_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tlpt_pkg::ctrl_cmd_t             cmd,
  output tlpt_pkg::ctrl_sts_t             sts,
  input  logic [tlpt_pkg::PAGE_W-1:0]     in_virt_page,
  input  logic [tlpt_pkg::PAGE_W-1:0]     in_phys_page,
  input  logic                            in_run_end,
  input  logic                            cfg_valid,
  input  logic [tlpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlpt_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_status,
  output logic                            out_table_allocated,
  output logic [tlpt_pkg::DIR_IDX_W-1:0]  out_dir_index,
  output logic [tlpt_pkg::WORD_W-1:0]     out_dir_word,
  output logic [tlpt_pkg::WORD_W-1:0]     out_pte_address,
  output logic [tlpt_pkg::WORD_W-1:0]     out_pte_word,
  output logic                            out_run_end_echo
);
  import tlpt_pkg::*;

  localparam int VP_LO_W = PAGE_W - DIR_IDX_W;

  logic [PAGE_W-1:0]     base_r;
  logic [POOL_CNT_W-1:0] pool_cnt_r;
  logic [NFT_W-1:0]      nft_r;
  logic [DIR_IDX_W-1:0]  clr_addr_r;

  logic [PAGE_W-1:0] vp_r;
  logic [PAGE_W-1:0] pp_r;
  logic              run_end_r;

  logic                 out_valid_r;
  logic                 status_r;
  logic                 alloc_r;
  logic [DIR_IDX_W-1:0] dir_index_r;
  logic [WORD_W-1:0]    dir_word_r;
  logic [WORD_W-1:0]    pte_addr_r;
  logic [WORD_W-1:0]    pte_word_r;
  logic                 run_end_echo_r;

  logic                 ram_we;
  logic [DIR_IDX_W-1:0] ram_waddr;
  logic [DIR_ENT_W-1:0] ram_wdata;
  logic [DIR_ENT_W-1:0] ram_rdata;

  logic                 ent_valid;
  logic [SLOT_W-1:0]    ent_slot;
  logic [CMP_W-1:0]     pool_eff;
  logic                 exhausted;
  logic                 alloc;
  logic [SLOT_W-1:0]    use_slot;
  logic [PAGE_W-1:0]    tpage;
  logic [DIR_IDX_W-1:0] dir_idx;

  assign dir_idx   = vp_r[PAGE_W-1:VP_LO_W];
  assign ent_valid = ram_rdata[DIR_ENT_W-1];
  assign ent_slot  = ram_rdata[SLOT_W-1:0];

  always_comb begin
    if (CMP_W'(pool_cnt_r) > CMP_W'(MAX_TABLES)) begin
      pool_eff = CMP_W'(MAX_TABLES);
    end else begin
      pool_eff = CMP_W'(pool_cnt_r);
    end
    exhausted = !ent_valid && (CMP_W'(nft_r) >= pool_eff);
    alloc     = !ent_valid && !exhausted;
    use_slot  = ent_valid ? ent_slot : nft_r[SLOT_W-1:0];
    tpage     = base_r + PAGE_W'(1) + PAGE_W'(use_slot);
  end

  always_comb begin
    ram_we    = cmd.clear_wr || (cmd.commit && alloc);
    ram_waddr = cmd.clear_wr ? clr_addr_r : dir_idx;
    ram_wdata = cmd.clear_wr ? '0 : {1'b1, nft_r[SLOT_W-1:0]};
  end

  tlpt_ram #(
    .WIDTH(DIR_ENT_W),
    .DEPTH(DIR_ENTRIES)
  ) u_dir_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.capture),
    .raddr(in_virt_page[PAGE_W-1:VP_LO_W]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      pool_cnt_r  <= POOL_CNT_RESET;
      nft_r       <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_DIR_BASE) begin
          base_r <= cfg_data[PAGE_W-1:0];
        end else if (cfg_index == REG_POOL_COUNT) begin
          pool_cnt_r <= cfg_data[POOL_CNT_W-1:0];
        end
      end
      if (cmd.clear_wr) begin
        clr_addr_r <= clr_addr_r + DIR_IDX_W'(1);
      end
      if (cmd.commit && alloc) begin
        nft_r <= nft_r + NFT_W'(1);
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vp_r      <= in_virt_page;
      pp_r      <= in_phys_page;
      run_end_r <= in_run_end;
    end
    if (cmd.commit) begin
      status_r       <= exhausted;
      alloc_r        <= alloc;
      dir_index_r    <= dir_idx;
      run_end_echo_r <= run_end_r;
      if (exhausted) begin
        dir_word_r <= '0;
        pte_addr_r <= '0;
        pte_word_r <= '0;
      end else begin
        dir_word_r <= {tpage, ENTRY_FLAGS};
        pte_addr_r <= {tpage, vp_r[VP_LO_W-1:0], 2'b00};
        pte_word_r <= {pp_r, ENTRY_FLAGS};
      end
    end
  end

  always_comb begin
    sts.clear_last = (clr_addr_r == DIR_IDX_W'(DIR_ENTRIES - 1));
    sts.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_table_allocated = alloc_r;
  assign out_dir_index       = dir_index_r;
  assign out_dir_word        = dir_word_r;
  assign out_pte_address     = pte_addr_r;
  assign out_pte_word        = pte_word_r;
  assign out_run_end_echo    = run_end_echo_r;
endmodule

@@ src/two_level_page_table_mapper.sv @@
// Two-level page table mapper.
// in_ch: one transaction per 4 KiB page (virt_page, phys_page, run_end).
// out_ch: one result transaction per input: status, table_allocated,
//   dir_index, dir_word, pte_address, pte_word, run_end_echo.
// cfg_ch: register writes (index 0 directory base page, 1 table pool count);
//   always ready, write only while idle. Other indexes are ignored.
// One page in flight: the next page is taken only after the directory RAM
//   read-modify-write (registered read, then write and result load) of
//   the current page is done.
// A new input is taken while a result still waits on out_ch; the lookup
//   holds in place while out_ch stalls, and input stays blocked meanwhile.
// Reset: synchronous, active low. Afterwards the directory RAM is swept
//   clear, one entry per cycle, all 1024 entries with in_ch.ready low.
//   Config regs return to base 0, pool count 8; allocation counter to 0.
module two_level_page_table_mapper (
  input  logic       clk,
  input  logic       rst_n,
  tlpt_in_if.sink    in_ch,
  tlpt_out_if.source out_ch,
  tlpt_cfg_if.sink   cfg_ch
);
  import tlpt_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  tlpt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  tlpt_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_virt_page       (in_ch.virt_page),
    .in_phys_page       (in_ch.phys_page),
    .in_run_end         (in_ch.run_end),
    .cfg_valid          (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_table_allocated(out_ch.table_allocated),
    .out_dir_index      (out_ch.dir_index),
    .out_dir_word       (out_ch.dir_word),
    .out_pte_address    (out_ch.pte_address),
    .out_pte_word       (out_ch.pte_word),
    .out_run_end_echo   (out_ch.run_end_echo)
  );
endmodule

@@ src/tlpt_checker.sv @@
module tlpt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_status,
  input logic [tlpt_pkg::WORD_W-1:0]    out_dir_word,
  input logic [tlpt_pkg::WORD_W-1:0]    out_pte_address,
  input logic [tlpt_pkg::DIR_IDX_W-1:0] out_dir_index
);
  import tlpt_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  ast_reset_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  ast_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second input taken while lookup in flight");

  ast_result_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("result appeared without matching input transaction");

  ast_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  ast_out_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_dir_word) &&
      $stable(out_pte_address) && $stable(out_dir_index))
    else $error("result payload changed while stalled");
endmodule

bind two_level_page_table_mapper tlpt_checker u_tlpt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_dir_word   (out_ch.dir_word),
  .out_pte_address(out_ch.pte_address),
  .out_dir_index  (out_ch.dir_index)
);

@@ bench/tlpt_tb_pkg.sv @@
package tlpt_tb_pkg;
  import tlpt_pkg::*;

  typedef struct packed {
    logic                 status;
    logic                 table_allocated;
    logic [DIR_IDX_W-1:0] dir_index;
    logic [WORD_W-1:0]    dir_word;
    logic [WORD_W-1:0]    pte_address;
    logic [WORD_W-1:0]    pte_word;
    logic                 run_end_echo;
  } page_map_t;

  class map_scoreboard;
    logic [PAGE_W-1:0]     dir_base;
    logic [POOL_CNT_W-1:0] pool_count;
    bit                    dir_live [DIR_ENTRIES];
    logic [NFT_W-1:0]      dir_slot [DIR_ENTRIES];
    logic [NFT_W-1:0]      tables_taken;
    page_map_t             pending[$];
    int                    errors;

    function new();
      dir_base = '0;
      pool_count = POOL_CNT_RESET;
      tables_taken = '0;
      errors = 0;
      foreach (dir_live[i]) begin
        dir_live[i] = 1'b0;
        dir_slot[i] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DIR_BASE: begin
          dir_base = data[PAGE_W-1:0];
        end
        REG_POOL_COUNT: begin
          pool_count = data[POOL_CNT_W-1:0];
        end
        default: ;
      endcase
    endfunction

    // predicts the mapping result of one accepted page and queues it
    function page_map_t map_page(logic [PAGE_W-1:0] vp, logic [PAGE_W-1:0] pp, logic last);
      page_map_t             r;
      logic [DIR_IDX_W-1:0]  di;
      logic [POOL_CNT_W-1:0] pool;
      logic [PAGE_W-1:0]     tpage;
      r = '0;
      di = vp[PAGE_W-1:PAGE_W-DIR_IDX_W];
      pool = (pool_count > MAX_TABLES) ? POOL_CNT_W'(MAX_TABLES) : pool_count;
      r.dir_index = di;
      r.run_end_echo = last;
      if (!dir_live[di] && tables_taken >= pool) begin
        r.status = 1'b1;
      end else begin
        if (!dir_live[di]) begin
          dir_live[di] = 1'b1;
          dir_slot[di] = tables_taken;
          tables_taken = tables_taken + NFT_W'(1);
          r.table_allocated = 1'b1;
        end
        tpage = dir_base + PAGE_W'(1) + PAGE_W'(dir_slot[di]);
        r.dir_word = {tpage, ENTRY_FLAGS};
        r.pte_address = {tpage, OFFS_W'(0)} + WORD_W'({vp[PAGE_W-DIR_IDX_W-1:0], 2'b00});
        r.pte_word = {pp, ENTRY_FLAGS};
      end
      pending.push_back(r);
      return r;
    endfunction

    task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      if (errors < 100)
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(page_map_t got);
      page_map_t want;
      if (pending.size() == 0) begin
        report("transaction with none expected, dir_index", WORD_W'(got.dir_index), '0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report("status", WORD_W'(got.status), WORD_W'(want.status));
      if (got.table_allocated !== want.table_allocated)
        report("table_allocated", WORD_W'(got.table_allocated), WORD_W'(want.table_allocated));
      if (got.dir_index !== want.dir_index)
        report("dir_index", WORD_W'(got.dir_index), WORD_W'(want.dir_index));
      if (got.dir_word !== want.dir_word)
        report("dir_word", got.dir_word, want.dir_word);
      if (got.pte_address !== want.pte_address)
        report("pte_address", got.pte_address, want.pte_address);
      if (got.pte_word !== want.pte_word)
        report("pte_word", got.pte_word, want.pte_word);
      if (got.run_end_echo !== want.run_end_echo)
        report("run_end_echo", WORD_W'(got.run_end_echo), WORD_W'(want.run_end_echo));
    endtask
  endclass

endpackage

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpt_pkg::*;
  import tlpt_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int OFF_W = PAGE_W - DIR_IDX_W;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 140;
  localparam int POOL_PLAN [PHASES] = '{16, 40, 64, 127, 5, 0, 33};
  localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = CFG_IDX_W'(2);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlpt_in_if  in_ch ();
  tlpt_out_if out_ch ();
  tlpt_cfg_if cfg_ch ();

  two_level_page_table_mapper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  map_scoreboard        book = new();
  logic [DIR_IDX_W-1:0] mapped_dirs[$];
  bit                   tx_calm;
  bit                   rx_calm;
  int                   rx_hold;
  int                   pages_sent;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  always @(posedge clk) begin : result_sink
    page_map_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status          = out_ch.status;
      got.table_allocated = out_ch.table_allocated;
      got.dir_index       = out_ch.dir_index;
      got.dir_word        = out_ch.dir_word;
      got.pte_address     = out_ch.pte_address;
      got.pte_word        = out_ch.pte_word;
      got.run_end_echo    = out_ch.run_end_echo;
      book.check_result(got);
      if ($urandom_range(19) == 0) rx_calm = !rx_calm;
      rx_hold = idle_len(rx_calm);
    end else if (rx_hold > 0) begin
      rx_hold--;
    end else if (!rx_calm && $urandom_range(15) == 0) begin
      rx_hold = $urandom_range(4, 1);
    end
    out_ch.ready <= (rx_hold == 0);
  end

  task automatic send_page(logic [PAGE_W-1:0] vp, logic [PAGE_W-1:0] pp, logic last);
    int        gap;
    page_map_t want;
    gap = idle_len(tx_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.virt_page <= vp;
    in_ch.phys_page <= pp;
    in_ch.run_end   <= last;
    do @(posedge clk); while (!in_ch.ready);
    want = book.map_page(vp, pp, last);
    if (want.table_allocated) mapped_dirs.push_back(want.dir_index);
    pages_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  // base, then an unmapped index that must be ignored, then pool count
  task automatic program_regs(logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] pool);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx[0] = REG_DIR_BASE;
    idx[1] = CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, FIRST_SPARE_REG));
    idx[2] = REG_POOL_COUNT;
    val[0] = base;
    val[1] = CFG_DATA_W'($urandom);
    val[2] = pool;
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
      book.write_reg(idx[i], val[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [PAGE_W-1:0] pick_page();
    logic [DIR_IDX_W-1:0] di;
    logic [OFF_W-1:0]     off;
    if (mapped_dirs.size() != 0 && $urandom_range(99) < 70)
      di = mapped_dirs[$urandom_range(mapped_dirs.size() - 1)];
    else
      di = DIR_IDX_W'($urandom);
    off = OFF_W'($urandom);
    if ($urandom_range(9) == 0) off = '1 - OFF_W'($urandom_range(3));
    return {di, off};
  endfunction

  // mostly contiguous page runs closed by run_end, some lone pages as noise
  task automatic send_run();
    logic [PAGE_W-1:0] vp;
    int                len;
    vp = pick_page();
    if ($urandom_range(9) == 0) tx_calm = !tx_calm;
    if ($urandom_range(99) < 85) begin
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++)
        send_page(vp + PAGE_W'(i), PAGE_W'($urandom), i == len - 1);
    end else begin
      send_page(vp, PAGE_W'($urandom), 1'($urandom));
    end
  endtask

  task automatic directed();
    send_page('0, '0, 1'b0);
    send_page('1, '1, 1'b1);
    send_page(PAGE_W'(20'h003FF), PAGE_W'(20'h5A5A5), 1'b1);
    for (int k = 1; k <= 6; k++)
      send_page({DIR_IDX_W'(k), OFF_W'($urandom)}, PAGE_W'($urandom), 1'b0);
    // pool of 8 now used up
    send_page({DIR_IDX_W'(500), OFF_W'($urandom)}, PAGE_W'($urandom), 1'b1);
    send_page(PAGE_W'(20'h00155), '1, 1'b0);
    program_regs('0, CFG_DATA_W'(20'hFFF80));
    send_page({DIR_IDX_W'(777), OFF_W'(10'h2AA)}, PAGE_W'(20'hAAAAA), 1'b1);
    send_page(PAGE_W'(20'hFFC00), PAGE_W'(20'h55555), 1'b0);
    // base at top of range wraps the table pages; pool count saturates
    program_regs('1, CFG_DATA_W'(127));
    send_page('0, PAGE_W'(20'h0F0F0), 1'b1);
    send_page('1, PAGE_W'(20'h12345), 1'b0);
    send_page({DIR_IDX_W'(900), OFF_W'(0)}, '0, 1'b1);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] base;
    logic [CFG_DATA_W-1:0] pool;
    int                    start;
    bit                    paused;
    in_ch.valid     = 1'b0;
    in_ch.virt_page = '0;
    in_ch.phys_page = '0;
    in_ch.run_end   = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    out_ch.ready    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    directed();
    for (int p = 0; p < PHASES; p++) begin
      base = (p == 1) ? '1 : (p == 3) ? '0 : CFG_DATA_W'($urandom);
      pool = CFG_DATA_W'($urandom);
      pool[POOL_CNT_W-1:0] = (p == PHASES - 1) ? POOL_CNT_W'($urandom)
                                               : POOL_CNT_W'(POOL_PLAN[p]);
      program_regs(base, pool);
      start = pages_sent;
      paused = 1'b0;
      while (pages_sent - start < PHASE_ITEMS) begin
        if (!paused && pages_sent - start >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        send_run();
      end
    end
    drain();
    repeat (20) @(posedge clk);
    if (book.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

endmodule
